// ----- rtl/core/sequence_reverse_complement_macros.svh -----
// assertion macros for the reverse complement block
`ifndef SEQUENCE_REVERSE_COMPLEMENT_MACROS_SVH
`define SEQUENCE_REVERSE_COMPLEMENT_MACROS_SVH

// checked outside reset
`define SRC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define SRC_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/srevc_pkg.sv -----
// shared types, constants and the complement lookup of the reverse complement block
`default_nettype none

package srevc_pkg;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_CR      = 8'd13;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] LINE_LENGTH_RESET = 8'd60;

  typedef struct packed {
    logic is_residue;
    logic last;
    logic empty;
    logic overflow;
  } resp_meta_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_CR) || (c == CHAR_NEWLINE);
  endfunction

  function automatic logic [7:0] complement_upper(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      "A":     r = "T";
      "T":     r = "A";
      "C":     r = "G";
      "G":     r = "C";
      "U":     r = "A";
      "R":     r = "Y";
      "Y":     r = "R";
      "M":     r = "K";
      "K":     r = "M";
      "H":     r = "D";
      "D":     r = "H";
      "B":     r = "V";
      "V":     r = "B";
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] complement(input logic [7:0] c);
    logic       lower;
    logic [7:0] u;
    logic [7:0] r;
    lower = (c >= "a") && (c <= "z");
    u = lower ? c - 8'd32 : c;
    r = complement_upper(u);
    if (lower && (r >= "A") && (r <= "Z")) begin
      r = r + 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sequence_reverse_complement.sv -----
// top level of the sequence reverse complement block
`default_nettype none

// Takes one item per clock while in_stall is low. A push (func 0) writes one residue into
// the store and gives no result; space, CR and LF are dropped, and residues beyond DEPTH
// set a sticky overflow. A pull (func 1) gives one byte: the store's registered read
// sits in the first stage, the complement lookup feeds the output register in the second.
// The store has one read port, so one pull is served per clock unless the input stalls. The output register frees
// the input while a result waits; the input stalls only when both stages are held.
// The first pull starts draining the record from its last residue; a newline follows every
// line_length residues (0 means 256) and the record always ends in one newline flagged last.
// Pushes during draining are ignored. The store needs no clearing pass after reset.
module sequence_reverse_complement #(
  parameter int DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last,
  output logic       empty_res,
  output logic       overflow
);

  import srevc_pkg::*;

  localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] stored_count, stored_count_next;
  logic [CW-1:0] read_position, read_position_next;
  logic [7:0]    column_count, column_count_next;
  logic          draining, draining_next;
  logic          newline_pending, newline_pending_next;
  logic          dropped_flag, dropped_flag_next;
  logic [7:0]    line_length;

  logic          s1_valid;
  resp_meta_t    s1_meta;
  resp_meta_t    res_meta;

  logic          s2_free, s1_adv, acc, pull_acc, push_acc;
  logic [CW-1:0] pos, pos_dec;
  logic [7:0]    col_base;
  logic [8:0]    col_inc, eff_len;
  logic [7:0]    out_byte_next;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  assign s2_free  = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && s2_free;
  assign in_stall = s1_valid && !s2_free;
  assign acc      = in_valid && !in_stall;
  assign pull_acc = acc && func;
  assign push_acc = acc && !func;

  assign eff_len  = {(line_length == 8'd0), line_length};
  assign pos      = draining ? read_position : stored_count;
  assign pos_dec  = pos - CW'(1);
  assign col_base = draining ? column_count : 8'd0;
  assign col_inc  = {1'b0, col_base} + 9'd1;

  always_comb begin
    stored_count_next    = stored_count;
    read_position_next   = read_position;
    column_count_next    = column_count;
    draining_next        = draining;
    newline_pending_next = newline_pending;
    dropped_flag_next    = dropped_flag;
    ram_we    = 1'b0;
    ram_waddr = stored_count[AW-1:0];
    ram_re    = 1'b0;
    ram_raddr = pos_dec[AW-1:0];
    res_meta  = '0;

    if (push_acc && !draining && !is_blank(symbol)) begin
      if (stored_count >= CW'(DEPTH)) begin
        dropped_flag_next = 1'b1;
      end else begin
        ram_we            = 1'b1;
        stored_count_next = stored_count + CW'(1);
      end
    end

    if (pull_acc) begin
      res_meta.overflow = dropped_flag;
      if (!draining && (stored_count == '0)) begin
        res_meta.empty    = 1'b1;
        res_meta.overflow = 1'b0;
      end else if (draining && newline_pending) begin
        newline_pending_next = 1'b0;
        if (read_position == '0) begin
          res_meta.last     = 1'b1;
          stored_count_next = '0;
          column_count_next = 8'd0;
          draining_next     = 1'b0;
          dropped_flag_next = 1'b0;
        end
      end else begin
        res_meta.is_residue = 1'b1;
        draining_next       = 1'b1;
        read_position_next  = pos_dec;
        ram_re              = 1'b1;
        if ((col_inc >= eff_len) || (pos_dec == '0)) begin
          newline_pending_next = 1'b1;
          column_count_next    = 8'd0;
        end else begin
          newline_pending_next = 1'b0;
          column_count_next    = col_inc[7:0];
        end
      end
    end
  end

  srevc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(symbol),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (s1_meta.is_residue) begin
      out_byte_next = complement(ram_rdata);
    end else if (s1_meta.empty) begin
      out_byte_next = 8'd0;
    end else begin
      out_byte_next = CHAR_NEWLINE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count    <= '0;
      read_position   <= '0;
      column_count    <= 8'd0;
      draining        <= 1'b0;
      newline_pending <= 1'b0;
      dropped_flag    <= 1'b0;
      line_length     <= LINE_LENGTH_RESET;
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      stored_count    <= stored_count_next;
      read_position   <= read_position_next;
      column_count    <= column_count_next;
      draining        <= draining_next;
      newline_pending <= newline_pending_next;
      dropped_flag    <= dropped_flag_next;
      if (cfg_we) begin
        line_length <= cfg_wdata;
      end
      if (pull_acc) begin
        s1_valid <= 1'b1;
        s1_meta  <= res_meta;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
        out_byte  <= out_byte_next;
        last      <= s1_meta.last;
        empty_res <= s1_meta.empty;
        overflow  <= s1_meta.overflow;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/srevc_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module srevc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/srevc_checker.sv -----
// port checker for the reverse complement block and its bind
`default_nettype none

`include "sequence_reverse_complement_macros.svh"

module srevc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last,
  input logic       empty_res,
  input logic       overflow
);

  import srevc_pkg::*;

  `SRC_CHECK_RST(a_idle_after_reset, rst |=> !out_valid, "result shown right after reset")
  `SRC_CHECK(a_empty_clean, (out_valid && empty_res) |-> ((out_byte == 8'd0) && !last && !overflow), "empty result carries data")
  `SRC_CHECK(a_last_is_newline, (out_valid && last) |-> ((out_byte == CHAR_NEWLINE) && !empty_res), "record end is not a newline")
  `SRC_CHECK(a_stalled_result_holds, (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(last)), "stalled result changed")

endmodule

bind sequence_reverse_complement srevc_checker u_srevc_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_byte (out_byte),
  .last     (last),
  .empty_res(empty_res),
  .overflow (overflow)
);

`default_nettype wire

// ----- test/tb.sv -----
// testbench for the sequence reverse complement block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srevc_pkg::*;

  localparam int STORE_DEPTH = 4096;

  typedef enum logic {FUNC_PUSH = 1'b0, FUNC_PULL = 1'b1} func_t;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    logic       none;
    logic       ovf;
  } strand_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       func = FUNC_PUSH;
  logic [7:0] symbol = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       last;
  logic       empty_res;
  logic       overflow;

  sequence_reverse_complement #(.DEPTH(STORE_DEPTH)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .symbol(symbol),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .last(last), .empty_res(empty_res), .overflow(overflow)
  );

  // strand state
  logic [7:0]  strand_mem [0:STORE_DEPTH-1];
  logic [7:0]  pair_of [0:255];
  int          held_count = 0;
  int          rd_pos = 0;
  int          col = 0;
  bit          draining = 0;
  bit          nl_pend = 0;
  bit          dropped = 0;
  logic [7:0]  row_len = LINE_LENGTH_RESET;
  strand_out_t pending_out[$];

  bit          idle_on = 1;
  int          hold_len = 0;
  int          err_count = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          records_done = 0;
  int          overflow_records = 0;
  int          length_settings = 0;
  string       alphabet = "ACGTUacgtuRYMKHDBVSWNrymkhdbvswn";

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void build_pairs();
    string p;
    logic [7:0] a;
    logic [7:0] b;
    p = "ATCGRYMKHDBV";
    for (int c = 0; c < 256; c++) pair_of[c] = c[7:0];
    for (int i = 0; i < p.len(); i += 2) begin
      a = p[i];
      b = p[i+1];
      pair_of[a] = b;
      pair_of[b] = a;
      pair_of[a + 8'd32] = b + 8'd32;
      pair_of[b + 8'd32] = a + 8'd32;
    end
    pair_of["U"] = "A";
    pair_of["u"] = "a";
  endfunction

  function automatic void predict_item(logic fn, logic [7:0] sym);
    int eff;
    strand_out_t r;
    eff = (row_len == 0) ? 256 : int'(row_len);
    if (fn == FUNC_PUSH) begin
      if (draining || sym == CHAR_SPACE || sym == CHAR_CR || sym == CHAR_NEWLINE) return;
      if (held_count >= STORE_DEPTH) begin
        dropped = 1;
        return;
      end
      strand_mem[held_count] = sym;
      held_count++;
      return;
    end
    if (!draining) begin
      if (held_count == 0) begin
        r = '{ch: 8'd0, fin: 1'b0, none: 1'b1, ovf: 1'b0};
        pending_out.push_back(r);
        return;
      end
      draining = 1;
      rd_pos = held_count;
      col = 0;
      nl_pend = 0;
    end
    r.none = 1'b0;
    r.ovf = dropped;
    r.fin = 1'b0;
    if (nl_pend) begin
      nl_pend = 0;
      r.ch = CHAR_NEWLINE;
      if (rd_pos == 0) begin
        r.fin = 1'b1;
        records_done++;
        if (dropped) overflow_records++;
        held_count = 0;
        col = 0;
        draining = 0;
        dropped = 0;
      end
      pending_out.push_back(r);
      return;
    end
    rd_pos--;
    r.ch = pair_of[strand_mem[rd_pos]];
    col++;
    if (col >= eff || rd_pos == 0) begin
      nl_pend = 1;
      col = 0;
    end
    pending_out.push_back(r);
  endfunction

  task automatic report_mismatch(string msg);
    if (err_count < 50) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    strand_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %h", out_byte));
      end else begin
        want = pending_out.pop_front();
        results_checked++;
        if (out_byte !== want.ch)
          report_mismatch($sformatf("out_byte %h, expected %h", out_byte, want.ch));
        if (last !== want.fin)
          report_mismatch($sformatf("last %b, expected %b", last, want.fin));
        if (empty_res !== want.none)
          report_mismatch($sformatf("empty_res %b, expected %b", empty_res, want.none));
        if (overflow !== want.ovf)
          report_mismatch($sformatf("overflow %b, expected %b", overflow, want.ovf));
      end
    end
  end

  // receiver side stalls
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(logic fn, logic [7:0] sym);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    symbol <= sym;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(fn, sym);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_line_length(logic [7:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    row_len = v;
    length_settings++;
  endtask

  function automatic logic [7:0] random_residue();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return alphabet[$urandom_range(0, alphabet.len() - 1)];
    if (pick < 80) return CHAR_SPACE;
    if (pick < 83) return CHAR_CR;
    if (pick < 86) return CHAR_NEWLINE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_record(int n);
    for (int i = 0; i < n; i++) send_item(FUNC_PUSH, random_residue());
  endtask

  task automatic pull_record();
    send_item(FUNC_PULL, 8'($urandom_range(0, 255)));
    while (draining) send_item(FUNC_PULL, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_basic_alphabet();
    logic [7:0] seq [] = '{"A", CHAR_SPACE, "c", CHAR_CR, "G", CHAR_NEWLINE, "t", "U", "u",
                           8'h00, 8'hFF, "S", "w", "R", "y", "M", "k", "H", "d", "B",
                           "v", "N"};
    send_item(FUNC_PULL, 8'h00);
    set_line_length(8'd5);
    foreach (seq[i]) send_item(FUNC_PUSH, seq[i]);
    send_item(FUNC_PULL, 8'hFF);
    send_item(FUNC_PUSH, "A");
    send_item(FUNC_PUSH, 8'hFF);
    pull_record();
    send_item(FUNC_PULL, 8'h5A);
  endtask

  task automatic test_line_lengths();
    logic [7:0] lens [] = '{8'd1, 8'd2, 8'd4, 8'd7, 8'd60, 8'd0};
    int eff;
    foreach (lens[i]) begin
      set_line_length(lens[i]);
      eff = (lens[i] == 0) ? 256 : int'(lens[i]);
      for (int k = 0; k < ((eff > 8) ? 1 : 4); k++) begin
        case (k)
          0: for (int j = 0; j < eff + 1; j++) send_item(FUNC_PUSH, "T");
          1: for (int j = 0; j < eff - 1; j++) send_item(FUNC_PUSH, "G");
          2: for (int j = 0; j < eff; j++) send_item(FUNC_PUSH, "a");
          default: for (int j = 0; j < 2 * eff; j++)
            send_item(FUNC_PUSH, alphabet[$urandom_range(0, alphabet.len() - 1)]);
        endcase
        pull_record();
      end
    end
  endtask

  task automatic test_length_change_midrecord();
    set_line_length(8'd10);
    push_record(60);
    repeat (8) send_item(FUNC_PULL, 8'h00);
    set_line_length(8'd3);
    repeat (6) send_item(FUNC_PULL, 8'h00);
    set_line_length(8'd0);
    repeat (5) send_item(FUNC_PULL, 8'h00);
    set_line_length(8'd1);
    pull_record();
    set_line_length(LINE_LENGTH_RESET);
  endtask

  task automatic test_backpressure();
    idle_on = 0;
    set_line_length(8'd16);
    push_record(40);
    wait_idle();
    hold_len = 200;
    repeat (30) send_item(FUNC_PULL, 8'h00);
    pull_record();
    wait_idle();
    idle_on = 1;
  endtask

  task automatic test_random_records();
    int stop_at;
    int pick;
    int n;
    stop_at = items_sent + 650;
    while (items_sent < stop_at) begin
      idle_on = (stop_at - items_sent) > 250;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 14) == 0) begin
        case ($urandom_range(0, 3))
          0: set_line_length(8'd0);
          1: set_line_length(8'd1);
          2: set_line_length(8'd255);
          default: set_line_length(8'($urandom_range(1, 80)));
        endcase
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 150) : $urandom_range(0, 30);
      if (pick < 70) begin
        push_record(n);
        pull_record();
      end else if (pick < 85) begin
        push_record(n);
        repeat ($urandom_range(1, 6)) send_item(FUNC_PULL, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 4)) send_item(FUNC_PUSH, 8'($urandom_range(0, 255)));
        pull_record();
      end else begin
        repeat ($urandom_range(1, 8))
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        pull_record();
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("sequence_reverse_complement test failed");
    $finish;
  end

  initial begin
    int guard;
    build_pairs();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_alphabet();
    test_line_lengths();
    test_length_change_midrecord();
    test_backpressure();
    test_random_records();
    in_valid <= 1'b0;
    guard = 0;
    while (pending_out.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (pending_out.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_out.size()));
    $display("ran %0d transfers in, checked %0d results over %0d records",
             items_sent, results_checked, records_done);
    $display("%0d records overflowed the store, %0d line length writes, %0d mismatches",
             overflow_records, length_settings, err_count);
    if (err_count == 0) begin
      $display("sequence_reverse_complement test passed");
    end else begin
      $display("sequence_reverse_complement test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/srevc_pkg.sv
rtl/core/srevc_ram.sv
rtl/core/sequence_reverse_complement.sv
rtl/core/srevc_checker.sv
test/tb.sv
